### rtl/rate_limited_vehicle_kinematics_step_top_defines.svh
// Assertion macros of the kinematics step top level.
`ifndef RATE_LIMITED_VEHICLE_KINEMATICS_STEP_TOP_DEFINES_SVH
`define RATE_LIMITED_VEHICLE_KINEMATICS_STEP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define RLVK_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define RLVK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rlvk_pkg.sv
// Shared constants, types and helpers of the kinematics step block.
`timescale 1ns / 1ps
package rlvk_pkg;

  localparam int NUM_W    = 54;
  localparam int DEN_W    = 26;
  localparam int DIV_ITER = NUM_W / 2;
  localparam int MA_W     = 34;
  localparam int MB_W     = 33;
  localparam int P_W      = MA_W + MB_W;

  localparam logic [DEN_W-1:0] US_PER_S = DEN_W'(1000000);
  localparam logic [DEN_W-1:0] POS_DIV  = DEN_W'(65536000);
  localparam logic [30:0]      Q30_ONE  = 31'h4000_0000;

  localparam logic [2:0] REG_HEADING_GAIN   = 3'd0;
  localparam logic [2:0] REG_HEADING_LAG    = 3'd1;
  localparam logic [2:0] REG_MAX_TURN_RATE  = 3'd2;
  localparam logic [2:0] REG_MAX_FWD_SPEED  = 3'd3;
  localparam logic [2:0] REG_MAX_REV_SPEED  = 3'd4;
  localparam logic [2:0] REG_ACCEL_LIMIT    = 3'd5;
  localparam logic [2:0] REG_MAX_DEPTH_RATE = 3'd6;
  localparam logic [2:0] REG_FLOOR_DEPTH    = 3'd7;

  localparam logic [1:0] FR_DEPTH = 2'd0;
  localparam logic [1:0] FR_OTHER = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ERR, ST_GMUL, ST_GRND, ST_EMUL, ST_EDIV, ST_DEM,
    ST_LMUL, ST_LDIV, ST_LUPD, ST_HMUL, ST_HDIV, ST_HUPD,
    ST_AMUL, ST_ADIV, ST_AUPD, ST_DMUL, ST_DDIV, ST_DUPD,
    ST_SANG, ST_XMUL, ST_X2, ST_TMUL, ST_TDIV, ST_TUPD,
    ST_SMUL, ST_SRND, ST_VMUL, ST_VSUM, ST_PMUL, ST_PDIV, ST_PUPD,
    ST_DWAIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  // Wraps an angle into [-pi, pi) in Q2.13; one correction covers the input range.
  function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] x);
    logic signed [18:0] r;
    r = 19'(x) + 19'sd25736;
    if (r < 0) begin
      r = r + 19'sd51472;
    end else if (r >= 19'sd51472) begin
      r = r - 19'sd51472;
    end
    return 16'(r - 19'sd25736);
  endfunction

  // Divisors of the sine series, innermost term first.
  function automatic logic [DEN_W-1:0] taylor_div(input logic [2:0] i);
    logic [DEN_W-1:0] d;
    case (i)
      3'd0:    d = DEN_W'(110);
      3'd1:    d = DEN_W'(72);
      3'd2:    d = DEN_W'(42);
      3'd3:    d = DEN_W'(20);
      default: d = DEN_W'(6);
    endcase
    return d;
  endfunction

endpackage

### rtl/rlvk_div.sv
// Radix-4 restoring divider shared by every quotient of the step.
`timescale 1ns / 1ps
module rlvk_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlvk_pkg::div_req_t  req_i,
  output rlvk_pkg::div_rsp_t  rsp_o
);

  logic                       busy_q, done_q;
  logic [4:0]                 cnt_q;
  logic [rlvk_pkg::NUM_W-1:0] n_q, n_d;
  logic [rlvk_pkg::DEN_W-1:0] r_q, r_d, d_q, r1;
  logic [rlvk_pkg::DEN_W:0]   t1, t2;
  logic                       b1, b2;

  // Two quotient bits per cycle.
  always_comb begin
    t1 = {r_q, n_q[rlvk_pkg::NUM_W-1]};
    if (t1 >= {1'b0, d_q}) begin
      r1 = rlvk_pkg::DEN_W'(t1 - {1'b0, d_q});
      b1 = 1'b1;
    end else begin
      r1 = t1[rlvk_pkg::DEN_W-1:0];
      b1 = 1'b0;
    end
    t2 = {r1, n_q[rlvk_pkg::NUM_W-2]};
    if (t2 >= {1'b0, d_q}) begin
      r_d = rlvk_pkg::DEN_W'(t2 - {1'b0, d_q});
      b2  = 1'b1;
    end else begin
      r_d = t2[rlvk_pkg::DEN_W-1:0];
      b2  = 1'b0;
    end
    n_d = {n_q[rlvk_pkg::NUM_W-3:0], b1, b2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(rlvk_pkg::DIV_ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q <= req_i.num;
      r_q <= '0;
      d_q <= req_i.den;
    end else if (busy_q) begin
      n_q <= n_d;
      r_q <= r_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = n_q;

endmodule

### rtl/rate_limited_vehicle_kinematics_step_top.sv
// Top level of the rate-limited vehicle kinematics step with its sequencer and datapath.
// Each accepted word is worked through by the sequencer, which sends its quotients to the shared
// radix-4 divider (27 iterations a quotient) 14 to 17 times.
// A new tick is taken only once the last result is loaded; a zero-length tick is taken and dropped.
// Reset (asynchronous, active low) restores register defaults and zeroes the vehicle state.
`timescale 1ns / 1ps
`include "rate_limited_vehicle_kinematics_step_top_defines.svh"
module rate_limited_vehicle_kinematics_step_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [19:0]        tick_us_i,
  input  logic               setpoint_valid_i,
  input  logic signed [15:0] target_heading_i,
  input  logic signed [15:0] target_speed_i,
  input  logic               elevation_valid_i,
  input  logic [1:0]         elevation_frame_i,
  input  logic signed [20:0] elevation_i,
  input  logic signed [15:0] current_east_i,
  input  logic signed [15:0] current_north_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] heading_out_o,
  output logic signed [15:0] yaw_rate_out_o,
  output logic signed [15:0] speed_out_o,
  output logic [19:0]        depth_out_o,
  output logic signed [47:0] east_pos_o,
  output logic signed [47:0] north_pos_o
);

  localparam int NW = rlvk_pkg::NUM_W;
  localparam int DW = rlvk_pkg::DEN_W;
  localparam int PW = rlvk_pkg::P_W;

  // Configuration registers.
  logic [15:0] gain_q, acc_q;
  logic [23:0] lag_q;
  logic [14:0] mtr_q, mfs_q, mrs_q, mdr_q;
  logic [19:0] flr_q;

  // Vehicle state that persists from tick to tick.
  logic signed [15:0] hd_q, yaw_q, spd_q;
  logic [19:0]        dep_q;
  logic [47:0]        east_q, north_q;

  // The word being worked on, captured at acceptance.
  logic [19:0]        dt_q;
  logic               sp_q, ev_q;
  logic [1:0]         fr_q;
  logic signed [15:0] tgt_h_q, tgt_v_q, ce_q, cn_q;
  logic signed [20:0] elev_q;

  // Working registers of the sequence.
  rlvk_pkg::state_e     state_q, state_d, ret_q;
  logic signed [15:0]   e_q, tv_q, dem_q;
  logic [30:0]          x_q, t_q;
  logic [31:0]          x2_q;
  logic [2:0]           ti_q;
  logic                 sneg_q, axis_q, dsgn_q;
  logic signed [17:0]   s16_q;
  logic signed [33:0]   vel_q;
  logic signed [PW-1:0] p_q;

  // Result register, which decouples the output handshake from the sequencer.
  logic               ovalid_q;
  logic signed [15:0] o_hd_q, o_yaw_q, o_spd_q;
  logic [19:0]        o_dep_q;
  logic [47:0]        o_east_q, o_north_q;

  rlvk_pkg::div_req_t div_req;
  rlvk_pkg::div_rsp_t div_rsp;

  logic                    in_take, dep_go, out_load;
  logic signed [33:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic signed [PW-1:0]    mul_p;
  logic [PW-1:0]           pmag;
  logic signed [NW:0]      qs, dem_w, mtr_w, gr_s;
  logic [33:0]             gr_sum;
  logic signed [15:0]      dem_c, ang, e_c, tv_c;
  logic [15:0]             a_abs, a_f;
  logic signed [16:0]      tv_raw, tv_hi, tv_lo, ldiff;
  logic signed [17:0]      sd, sstep, sdc;
  logic signed [22:0]      td_raw, td_c, flr_w, dep_w, dd, dstep, ddc, nd, nd_c;
  logic [32:0]             s_sum;
  logic [17:0]             s_mag;

  assign in_ready_o = (state_q == rlvk_pkg::ST_IDLE);
  assign in_take    = in_valid_i && in_ready_o;
  assign dep_go     = sp_q && ev_q && (fr_q != rlvk_pkg::FR_OTHER);
  assign out_load   = (state_q == rlvk_pkg::ST_DONE) && (!ovalid_q || out_ready_i);

  rlvk_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // The single multiplier; its product is registered before anything uses it.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      rlvk_pkg::ST_GMUL: begin
        mul_a = 34'($signed({1'b0, gain_q}));
        mul_b = 33'(e_q);
      end
      rlvk_pkg::ST_EMUL: begin
        mul_a = 34'(e_q);
        mul_b = 33'($signed({1'b0, rlvk_pkg::US_PER_S}));
      end
      rlvk_pkg::ST_LMUL: begin
        mul_a = 34'($signed({1'b0, dt_q}));
        mul_b = 33'(ldiff);
      end
      rlvk_pkg::ST_HMUL: begin
        mul_a = 34'(yaw_q);
        mul_b = 33'($signed({1'b0, dt_q}));
      end
      rlvk_pkg::ST_AMUL: begin
        mul_a = 34'($signed({1'b0, acc_q}));
        mul_b = 33'($signed({1'b0, dt_q}));
      end
      rlvk_pkg::ST_DMUL: begin
        mul_a = 34'($signed({1'b0, mdr_q}));
        mul_b = 33'($signed({1'b0, dt_q}));
      end
      rlvk_pkg::ST_XMUL: begin
        mul_a = 34'($signed({1'b0, x_q}));
        mul_b = 33'($signed({1'b0, x_q}));
      end
      rlvk_pkg::ST_TMUL: begin
        mul_a = 34'($signed({1'b0, x2_q}));
        mul_b = 33'($signed({1'b0, t_q}));
      end
      rlvk_pkg::ST_SMUL: begin
        mul_a = 34'($signed({1'b0, x_q}));
        mul_b = 33'($signed({1'b0, t_q}));
      end
      rlvk_pkg::ST_VMUL: begin
        mul_a = 34'(spd_q);
        mul_b = 33'(s16_q);
      end
      rlvk_pkg::ST_PMUL: begin
        mul_a = vel_q;
        mul_b = 33'($signed({1'b0, dt_q}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);
  assign pmag  = p_q[PW-1] ? PW'(-p_q) : PW'(p_q);

  // Division requests. Rounded quotients divide the magnitude plus half the divisor and
  // take the sign back afterwards; the sine series truncates.
  always_comb begin
    div_req.start = 1'b0;
    div_req.den   = rlvk_pkg::US_PER_S;
    case (state_q)
      rlvk_pkg::ST_EDIV: begin
        div_req.start = 1'b1;
        div_req.den   = DW'(dt_q);
      end
      rlvk_pkg::ST_LDIV: begin
        div_req.start = 1'b1;
        div_req.den   = DW'(lag_q) + DW'(dt_q);
      end
      rlvk_pkg::ST_HDIV, rlvk_pkg::ST_ADIV, rlvk_pkg::ST_DDIV: begin
        div_req.start = 1'b1;
        div_req.den   = rlvk_pkg::US_PER_S;
      end
      rlvk_pkg::ST_PDIV: begin
        div_req.start = 1'b1;
        div_req.den   = rlvk_pkg::POS_DIV;
      end
      rlvk_pkg::ST_TDIV: begin
        div_req.start = 1'b1;
        div_req.den   = rlvk_pkg::taylor_div(ti_q);
      end
      default: begin
        div_req.start = 1'b0;
        div_req.den   = rlvk_pkg::US_PER_S;
      end
    endcase
    if (state_q == rlvk_pkg::ST_TDIV) begin
      div_req.num = NW'(p_q[61:30]);
    end else begin
      div_req.num = NW'(pmag) + NW'(div_req.den[DW-1:1]);
    end
  end

  assign qs = dsgn_q ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});

  // Heading error and clamped speed target.
  always_comb begin
    e_c    = rlvk_pkg::wrap_ang(18'(sp_q ? tgt_h_q : hd_q) - 18'(hd_q));
    tv_raw = sp_q ? 17'(tgt_v_q) : '0;
    tv_hi  = $signed({2'b0, mfs_q});
    tv_lo  = -$signed({2'b0, mrs_q});
    if (tv_raw < tv_lo) begin
      tv_c = 16'(tv_lo);
    end else if (tv_raw > tv_hi) begin
      tv_c = 16'(tv_hi);
    end else begin
      tv_c = 16'(tv_raw);
    end
  end

  // Demanded yaw rate, from the gain path or the reciprocal-tick path, clamped to the limit.
  always_comb begin
    gr_sum = pmag[33:0] + 34'd128;
    gr_s   = p_q[PW-1] ? -$signed({29'b0, gr_sum[33:8]}) : $signed({29'b0, gr_sum[33:8]});
    dem_w  = (state_q == rlvk_pkg::ST_GRND) ? gr_s : qs;
    mtr_w  = $signed({{(NW + 1 - 15){1'b0}}, mtr_q});
    if (dem_w > mtr_w) begin
      dem_c = 16'(mtr_w);
    end else if (dem_w < -mtr_w) begin
      dem_c = 16'(-mtr_w);
    end else begin
      dem_c = 16'(dem_w);
    end
    ldiff = 17'(dem_q) - 17'(yaw_q);
  end

  // Speed slew.
  always_comb begin
    sstep = $signed({1'b0, qs[16:0]});
    sd    = 18'(tv_q) - 18'(spd_q);
    if (sd > sstep) begin
      sdc = sstep;
    end else if (sd < -sstep) begin
      sdc = -sstep;
    end else begin
      sdc = sd;
    end
  end

  // Depth slew toward the depth target, then the floor bounds.
  always_comb begin
    flr_w  = $signed({3'b0, flr_q});
    dep_w  = $signed({3'b0, dep_q});
    td_raw = (fr_q == rlvk_pkg::FR_DEPTH) ? 23'(elev_q) : flr_w - 23'(elev_q);
    if (td_raw < 0) begin
      td_c = '0;
    end else if (td_raw > flr_w) begin
      td_c = flr_w;
    end else begin
      td_c = td_raw;
    end
    dstep = $signed({7'b0, qs[15:0]});
    dd    = td_c - dep_w;
    if (dd > dstep) begin
      ddc = dstep;
    end else if (dd < -dstep) begin
      ddc = -dstep;
    end else begin
      ddc = dd;
    end
    nd = dep_w + ddc;
    if (nd < 0) begin
      nd_c = '0;
    end else if (nd > flr_w) begin
      nd_c = flr_w;
    end else begin
      nd_c = nd;
    end
  end

  // Angle folding for the sine series, and rounding of its result to Q16.
  always_comb begin
    ang   = axis_q ? rlvk_pkg::wrap_ang(18'(hd_q) + 18'sd12868) : hd_q;
    a_abs = ang[15] ? 16'(-ang) : 16'(ang);
    a_f   = (a_abs > 16'd12868) ? 16'd25736 - a_abs : a_abs;
    s_sum = {1'b0, p_q[61:30]} + 33'd8192;
    s_mag = s_sum[31:14];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rlvk_pkg::ST_IDLE: if (in_take && (tick_us_i != '0)) state_d = rlvk_pkg::ST_ERR;
      rlvk_pkg::ST_ERR:  state_d = (gain_q != '0) ? rlvk_pkg::ST_GMUL : rlvk_pkg::ST_EMUL;
      rlvk_pkg::ST_GMUL: state_d = rlvk_pkg::ST_GRND;
      rlvk_pkg::ST_GRND, rlvk_pkg::ST_DEM: begin
        state_d = (lag_q != '0) ? rlvk_pkg::ST_LMUL : rlvk_pkg::ST_HMUL;
      end
      rlvk_pkg::ST_EMUL: state_d = rlvk_pkg::ST_EDIV;
      rlvk_pkg::ST_LMUL: state_d = rlvk_pkg::ST_LDIV;
      rlvk_pkg::ST_LUPD: state_d = rlvk_pkg::ST_HMUL;
      rlvk_pkg::ST_HMUL: state_d = rlvk_pkg::ST_HDIV;
      rlvk_pkg::ST_HUPD: state_d = rlvk_pkg::ST_AMUL;
      rlvk_pkg::ST_AMUL: state_d = rlvk_pkg::ST_ADIV;
      rlvk_pkg::ST_AUPD: state_d = dep_go ? rlvk_pkg::ST_DMUL : rlvk_pkg::ST_SANG;
      rlvk_pkg::ST_DMUL: state_d = rlvk_pkg::ST_DDIV;
      rlvk_pkg::ST_DUPD: state_d = rlvk_pkg::ST_SANG;
      rlvk_pkg::ST_SANG: state_d = rlvk_pkg::ST_XMUL;
      rlvk_pkg::ST_XMUL: state_d = rlvk_pkg::ST_X2;
      rlvk_pkg::ST_X2:   state_d = rlvk_pkg::ST_TMUL;
      rlvk_pkg::ST_TMUL: state_d = rlvk_pkg::ST_TDIV;
      rlvk_pkg::ST_TUPD: state_d = (ti_q == 3'd4) ? rlvk_pkg::ST_SMUL : rlvk_pkg::ST_TMUL;
      rlvk_pkg::ST_SMUL: state_d = rlvk_pkg::ST_SRND;
      rlvk_pkg::ST_SRND: state_d = rlvk_pkg::ST_VMUL;
      rlvk_pkg::ST_VMUL: state_d = rlvk_pkg::ST_VSUM;
      rlvk_pkg::ST_VSUM: state_d = rlvk_pkg::ST_PMUL;
      rlvk_pkg::ST_PMUL: state_d = rlvk_pkg::ST_PDIV;
      rlvk_pkg::ST_PUPD: state_d = axis_q ? rlvk_pkg::ST_DONE : rlvk_pkg::ST_SANG;
      rlvk_pkg::ST_EDIV, rlvk_pkg::ST_LDIV, rlvk_pkg::ST_HDIV, rlvk_pkg::ST_ADIV,
      rlvk_pkg::ST_DDIV, rlvk_pkg::ST_TDIV, rlvk_pkg::ST_PDIV: begin
        state_d = rlvk_pkg::ST_DWAIT;
      end
      rlvk_pkg::ST_DWAIT: if (div_rsp.done) state_d = ret_q;
      rlvk_pkg::ST_DONE:  if (out_load) state_d = rlvk_pkg::ST_IDLE;
      default:            state_d = rlvk_pkg::ST_IDLE;
    endcase
  end

  // Control state, configuration and vehicle state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rlvk_pkg::ST_IDLE;
      ovalid_q <= 1'b0;
      gain_q   <= 16'd0;
      lag_q    <= 24'd0;
      mtr_q    <= 15'd2048;
      mfs_q    <= 15'd5000;
      mrs_q    <= 15'd0;
      acc_q    <= 16'd0;
      mdr_q    <= 15'd500;
      flr_q    <= 20'd100000;
      hd_q     <= '0;
      yaw_q    <= '0;
      spd_q    <= '0;
      dep_q    <= '0;
      east_q   <= '0;
      north_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rlvk_pkg::REG_HEADING_GAIN:   gain_q <= cfg_data_i[15:0];
          rlvk_pkg::REG_HEADING_LAG:    lag_q  <= cfg_data_i;
          rlvk_pkg::REG_MAX_TURN_RATE:  mtr_q  <= cfg_data_i[14:0];
          rlvk_pkg::REG_MAX_FWD_SPEED:  mfs_q  <= cfg_data_i[14:0];
          rlvk_pkg::REG_MAX_REV_SPEED:  mrs_q  <= cfg_data_i[14:0];
          rlvk_pkg::REG_ACCEL_LIMIT:    acc_q  <= cfg_data_i[15:0];
          rlvk_pkg::REG_MAX_DEPTH_RATE: mdr_q  <= cfg_data_i[14:0];
          rlvk_pkg::REG_FLOOR_DEPTH:    flr_q  <= cfg_data_i[19:0];
          default:                      gain_q <= gain_q;
        endcase
      end
      case (state_q)
        rlvk_pkg::ST_GRND, rlvk_pkg::ST_DEM: if (lag_q == '0) yaw_q <= dem_c;
        rlvk_pkg::ST_LUPD: yaw_q   <= 16'(17'(yaw_q) + 17'(qs));
        rlvk_pkg::ST_HUPD: hd_q    <= rlvk_pkg::wrap_ang(18'(hd_q) + 18'(qs));
        rlvk_pkg::ST_AUPD: spd_q   <= 16'(18'(spd_q) + sdc);
        rlvk_pkg::ST_DUPD: dep_q   <= nd_c[19:0];
        rlvk_pkg::ST_PUPD: begin
          if (axis_q) begin
            north_q <= north_q + 48'(qs);
          end else begin
            east_q  <= east_q + 48'(qs);
          end
        end
        default: hd_q <= hd_q;
      endcase
    end
  end

  // Captured word, working registers and result payload.
  always_ff @(posedge clk_i) begin
    p_q <= mul_p;
    if (in_take) begin
      dt_q    <= tick_us_i;
      sp_q    <= setpoint_valid_i;
      tgt_h_q <= target_heading_i;
      tgt_v_q <= target_speed_i;
      ev_q    <= elevation_valid_i;
      fr_q    <= elevation_frame_i;
      elev_q  <= elevation_i;
      ce_q    <= current_east_i;
      cn_q    <= current_north_i;
    end
    if (div_req.start) begin
      dsgn_q <= p_q[PW-1];
    end
    case (state_q)
      rlvk_pkg::ST_ERR: begin
        e_q    <= e_c;
        tv_q   <= tv_c;
        axis_q <= 1'b0;
      end
      rlvk_pkg::ST_GRND, rlvk_pkg::ST_DEM: dem_q <= dem_c;
      rlvk_pkg::ST_EDIV: ret_q <= rlvk_pkg::ST_DEM;
      rlvk_pkg::ST_LDIV: ret_q <= rlvk_pkg::ST_LUPD;
      rlvk_pkg::ST_HDIV: ret_q <= rlvk_pkg::ST_HUPD;
      rlvk_pkg::ST_ADIV: ret_q <= rlvk_pkg::ST_AUPD;
      rlvk_pkg::ST_DDIV: ret_q <= rlvk_pkg::ST_DUPD;
      rlvk_pkg::ST_TDIV: ret_q <= rlvk_pkg::ST_TUPD;
      rlvk_pkg::ST_PDIV: ret_q <= rlvk_pkg::ST_PUPD;
      rlvk_pkg::ST_SANG: begin
        sneg_q <= ang[15];
        x_q    <= {a_f[13:0], 17'b0};
      end
      rlvk_pkg::ST_X2: begin
        x2_q <= p_q[61:30];
        t_q  <= rlvk_pkg::Q30_ONE;
        ti_q <= '0;
      end
      rlvk_pkg::ST_TUPD: begin
        t_q  <= rlvk_pkg::Q30_ONE - div_rsp.quo[30:0];
        ti_q <= ti_q + 3'd1;
      end
      rlvk_pkg::ST_SRND: begin
        s16_q <= sneg_q ? -$signed(s_mag) : $signed(s_mag);
      end
      rlvk_pkg::ST_VSUM: begin
        vel_q <= $signed(p_q[33:0]) + 34'($signed({axis_q ? cn_q : ce_q, 16'h0000}));
      end
      rlvk_pkg::ST_PUPD: axis_q <= 1'b1;
      default: ret_q <= ret_q;
    endcase
    if (out_load) begin
      o_hd_q    <= hd_q;
      o_yaw_q   <= yaw_q;
      o_spd_q   <= spd_q;
      o_dep_q   <= dep_q;
      o_east_q  <= east_q;
      o_north_q <= north_q;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign heading_out_o  = o_hd_q;
  assign yaw_rate_out_o = o_yaw_q;
  assign speed_out_o    = o_spd_q;
  assign depth_out_o    = o_dep_q;
  assign east_pos_o     = $signed(o_east_q);
  assign north_pos_o    = $signed(o_north_q);

  // The heading is always kept wrapped into [-pi, pi).
  `RLVK_ASSERT(a_hd_range, 1'b1, (hd_q >= -16'sd25736) && (hd_q <= 16'sd25735),
               "heading out of wrap range")
  // The yaw rate is bounded by a 15-bit limit and never reaches the negative extreme.
  `RLVK_ASSERT(a_yaw_range, 1'b1, yaw_q != -16'sd32768, "yaw rate beyond its limit")
  // Waiting on the divider only makes sense while it is running or just finishing.
  `RLVK_ASSERT(a_wait_div, state_q == rlvk_pkg::ST_DWAIT, div_rsp.busy || div_rsp.done,
               "wait without a division")
  // A finished tick holds until the result register is free.
  `RLVK_ASSERT_NXT(a_hold_done, (state_q == rlvk_pkg::ST_DONE) && ovalid_q && !out_ready_i,
                   state_q == rlvk_pkg::ST_DONE, "result overwritten")

endmodule

### tb/rate_limited_vehicle_kinematics_step_top_tb.sv
// Self-checking testbench of the rate-limited vehicle kinematics step block.
`timescale 1ns / 1ps
module rate_limited_vehicle_kinematics_step_top_tb;

  // Fixed-point angle constants in Q2.13.
  localparam longint PI_Q      = 25736;
  localparam longint TWO_PI_Q  = 51472;
  localparam longint HALF_PI_Q = 12868;
  localparam longint MICRO     = 1000000;
  // Settling time that covers any work of a tick still in flight.
  localparam int     SETTLE_CYCLES = 700;

  // One tick word as it is driven onto the input channel.
  typedef struct {
    logic [19:0]        tick_us;
    logic               sp_valid;
    logic signed [15:0] tgt_heading;
    logic signed [15:0] tgt_speed;
    logic               elev_valid;
    logic [1:0]         elev_frame;
    logic signed [20:0] elevation;
    logic signed [15:0] cur_east;
    logic signed [15:0] cur_north;
  } tick_word_t;

  // The vehicle state reported after one tick.
  typedef struct {
    logic signed [15:0] heading;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] speed;
    logic [19:0]        depth;
    logic [47:0]        east;
    logic [47:0]        north;
  } pose_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [23:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [19:0]        tick_us_i;
  logic               setpoint_valid_i;
  logic signed [15:0] target_heading_i;
  logic signed [15:0] target_speed_i;
  logic               elevation_valid_i;
  logic [1:0]         elevation_frame_i;
  logic signed [20:0] elevation_i;
  logic signed [15:0] current_east_i;
  logic signed [15:0] current_north_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] heading_out_o;
  logic signed [15:0] yaw_rate_out_o;
  logic signed [15:0] speed_out_o;
  logic [19:0]        depth_out_o;
  logic signed [47:0] east_pos_o;
  logic signed [47:0] north_pos_o;

  rate_limited_vehicle_kinematics_step_top dut (.*);

  // Shadow copies of the registers and of the vehicle state, kept by the predictor.
  longint gain_q8, lag_us, turn_lim, fwd_lim, rev_lim, accel_lim, depth_rate_lim, floor_mm;
  longint veh_heading, veh_yaw, veh_speed, veh_depth;
  logic [47:0] veh_east, veh_north;

  pose_t expected_poses[$];
  int    mismatches;
  bit    no_idle;   // when set, neither side inserts gaps

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Fallback limit: far longer than the slowest correct run.
  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Division rounded to nearest, ties away from zero.
  function automatic longint rdiv(longint n, longint d);
    longint unsigned m, q;
    m = (n < 0) ? longint'(-n) : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Maps any angle into [-pi, pi) modulo two pi.
  function automatic longint wrap_q13(longint x);
    longint r;
    r = (x + PI_Q) % TWO_PI_Q;
    if (r < 0) r += TWO_PI_Q;
    return r - PI_Q;
  endfunction

  // Sine of a wrapped angle as a Q16 value, from a Q30 Taylor series to the eleventh power.
  function automatic longint sine_q16(longint h);
    longint unsigned one, x, x2, t, s, dv;
    longint a;
    one = 64'd1 << 30;
    a = (h < 0) ? -h : h;
    if (a > HALF_PI_Q) a = PI_Q - a;
    if (a < 0) a = 0;
    x  = longint'(a) << 17;
    x2 = (x * x) >> 30;
    t  = one;
    for (int i = 0; i < 5; i++) begin
      case (i)
        0: dv = 110;
        1: dv = 72;
        2: dv = 42;
        3: dv = 20;
        default: dv = 6;
      endcase
      t = one - ((x2 * t) >> 30) / dv;
    end
    s = (x * t) >> 30;
    s = (s + (64'd1 << 13)) >> 14;
    return (h < 0) ? -longint'(s) : longint'(s);
  endfunction

  function automatic logic [47:0] drift(logic [47:0] pos, longint s16, longint cur, longint dt);
    longint vel;
    vel = veh_speed * s16 + cur * 65536;
    return pos + 48'(rdiv(vel * dt, 64'd65536000));
  endfunction

  // Advances the shadow vehicle by one tick; returns 0 when the tick yields no pose.
  function automatic bit step_vehicle(tick_word_t w, output pose_t p);
    longint dt, th, tv, err, dem, stp, td;
    dt = w.tick_us;
    if (dt == 0) return 0;
    th = w.sp_valid ? longint'(w.tgt_heading) : veh_heading;
    tv = w.sp_valid ? longint'(w.tgt_speed) : 0;
    tv = clamp(tv, -rev_lim, fwd_lim);

    err = wrap_q13(th - veh_heading);
    dem = (gain_q8 != 0) ? rdiv(gain_q8 * err, 256) : rdiv(err * MICRO, dt);
    dem = clamp(dem, -turn_lim, turn_lim);
    if (lag_us != 0) veh_yaw += rdiv(dt * (dem - veh_yaw), lag_us + dt);
    else veh_yaw = dem;
    veh_heading = wrap_q13(veh_heading + rdiv(veh_yaw * dt, MICRO));

    stp = rdiv(accel_lim * dt, MICRO);
    veh_speed += clamp(tv - veh_speed, -stp, stp);

    // Depth only follows a valid setpoint with a usable elevation frame.
    if (w.sp_valid && w.elev_valid && w.elev_frame != rlvk_pkg::FR_OTHER) begin
      td  = (w.elev_frame == rlvk_pkg::FR_DEPTH) ? longint'(w.elevation)
                                                 : floor_mm - longint'(w.elevation);
      td  = clamp(td, 0, floor_mm);
      stp = rdiv(depth_rate_lim * dt, MICRO);
      veh_depth += clamp(td - veh_depth, -stp, stp);
      veh_depth = clamp(veh_depth, 0, floor_mm);
    end

    veh_east  = drift(veh_east, sine_q16(veh_heading), w.cur_east, dt);
    veh_north = drift(veh_north, sine_q16(wrap_q13(veh_heading + HALF_PI_Q)), w.cur_north, dt);

    p.heading  = 16'(veh_heading);
    p.yaw_rate = 16'(veh_yaw);
    p.speed    = 16'(veh_speed);
    p.depth    = 20'(veh_depth);
    p.east     = veh_east;
    p.north    = veh_north;
    return 1;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Sends one word and records the pose it should produce. On return the word has just
  // been accepted in the current time step, so the caller must either send the next word
  // or lower valid before time moves on.
  task automatic send_tick(tick_word_t w);
    int   gap;
    pose_t p;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    tick_us_i         <= w.tick_us;
    setpoint_valid_i  <= w.sp_valid;
    target_heading_i  <= w.tgt_heading;
    target_speed_i    <= w.tgt_speed;
    elevation_valid_i <= w.elev_valid;
    elevation_frame_i <= w.elev_frame;
    elevation_i       <= w.elevation;
    current_east_i    <= w.cur_east;
    current_north_i   <= w.cur_north;
    do @(posedge clk_i); while (!in_ready_o);
    if (step_vehicle(w, p)) expected_poses.push_back(p);
  endtask

  // Lowers valid and waits until the block has handed over every pending pose and
  // has had time to finish any tick that produces nothing.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic cfg_write(logic [2:0] idx, longint val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 24'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      rlvk_pkg::REG_HEADING_GAIN:   gain_q8        = val & 64'hFFFF;
      rlvk_pkg::REG_HEADING_LAG:    lag_us         = val & 64'hFFFFFF;
      rlvk_pkg::REG_MAX_TURN_RATE:  turn_lim       = val & 64'h7FFF;
      rlvk_pkg::REG_MAX_FWD_SPEED:  fwd_lim        = val & 64'h7FFF;
      rlvk_pkg::REG_MAX_REV_SPEED:  rev_lim        = val & 64'h7FFF;
      rlvk_pkg::REG_ACCEL_LIMIT:    accel_lim      = val & 64'hFFFF;
      rlvk_pkg::REG_MAX_DEPTH_RATE: depth_rate_lim = val & 64'h7FFF;
      default:                      floor_mm       = val & 64'hFFFFF;
    endcase
  endtask

  task automatic cfg_all(longint g, longint l, longint tr, longint fw, longint rv,
                         longint ac, longint dr, longint fl);
    cfg_write(rlvk_pkg::REG_HEADING_GAIN, g);
    cfg_write(rlvk_pkg::REG_HEADING_LAG, l);
    cfg_write(rlvk_pkg::REG_MAX_TURN_RATE, tr);
    cfg_write(rlvk_pkg::REG_MAX_FWD_SPEED, fw);
    cfg_write(rlvk_pkg::REG_MAX_REV_SPEED, rv);
    cfg_write(rlvk_pkg::REG_ACCEL_LIMIT, ac);
    cfg_write(rlvk_pkg::REG_MAX_DEPTH_RATE, dr);
    cfg_write(rlvk_pkg::REG_FLOOR_DEPTH, fl);
  endtask

  function automatic tick_word_t make_tick(longint dt, bit sp, longint hd, longint sv,
                                           bit ev, logic [1:0] fr, longint el,
                                           longint ce, longint cn);
    tick_word_t w;
    w.tick_us     = 20'(dt);
    w.sp_valid    = sp;
    w.tgt_heading = 16'(hd);
    w.tgt_speed   = 16'(sv);
    w.elev_valid  = ev;
    w.elev_frame  = fr;
    w.elevation   = 21'(el);
    w.cur_east    = 16'(ce);
    w.cur_north   = 16'(cn);
    return w;
  endfunction

  // Random tick, weighted towards sensible setpoints so the vehicle actually manoeuvres.
  function automatic tick_word_t random_tick();
    tick_word_t w;
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) w.tick_us = '0;
    else if (sel == 1) w.tick_us = 20'($urandom);
    else if (sel < 5) w.tick_us = 20'($urandom_range(1, 200));
    else w.tick_us = 20'($urandom_range(1000, 200000));
    w.sp_valid    = ($urandom_range(0, 7) != 0);
    w.tgt_heading = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                : 16'(longint'($urandom_range(0, 51471)) - PI_Q);
    w.tgt_speed   = 16'($urandom);
    w.elev_valid  = ($urandom_range(0, 3) != 0);
    w.elev_frame  = 2'($urandom);
    w.elevation   = ($urandom_range(0, 4) == 0) ? 21'($urandom)
                                                : 21'($urandom_range(0, 32'(floor_mm)));
    if ($urandom_range(0, 3) == 0) begin
      w.cur_east  = 16'($urandom);
      w.cur_north = 16'($urandom);
    end else begin
      w.cur_east  = 16'(longint'($urandom_range(0, 2000)) - 1000);
      w.cur_north = 16'(longint'($urandom_range(0, 2000)) - 1000);
    end
    return w;
  endfunction

  // ---------------------------------------------------------------- result side

  // The receiver draws a stall for every pose it takes; a single assignment per edge.
  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compares every accepted pose with the oldest one predicted.
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_poses.size() == 0) begin
        $error("pose word with no tick pending");
        mismatches++;
      end else begin
        e = expected_poses.pop_front();
        if (heading_out_o !== e.heading) begin
          $error("heading_out: expected %0d, got %0d", e.heading, heading_out_o);
          mismatches++;
        end
        if (yaw_rate_out_o !== e.yaw_rate) begin
          $error("yaw_rate_out: expected %0d, got %0d", e.yaw_rate, yaw_rate_out_o);
          mismatches++;
        end
        if (speed_out_o !== e.speed) begin
          $error("speed_out: expected %0d, got %0d", e.speed, speed_out_o);
          mismatches++;
        end
        if (depth_out_o !== e.depth) begin
          $error("depth_out: expected %0d, got %0d", e.depth, depth_out_o);
          mismatches++;
        end
        if (east_pos_o !== e.east) begin
          $error("east_pos: expected %0d, got %0d", $signed(e.east), east_pos_o);
          mismatches++;
        end
        if (north_pos_o !== e.north) begin
          $error("north_pos: expected %0d, got %0d", $signed(e.north), north_pos_o);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Default registers: extremes of every field, zero ticks, every elevation frame and
  // headings far outside the wrapped range.
  task automatic test_field_extremes;
    send_tick(make_tick(0, 1, 1000, 1000, 1, 0, 500, 100, 100));       // ignored
    send_tick(make_tick(100000, 1, 20000, 3000, 1, 0, 5000, 0, 0));
    send_tick(make_tick(1000000, 1, 25736, 32767, 1, 0, 1000000, 32767, 32767));
    send_tick(make_tick(20'hFFFFF, 1, -25736, -32768, 1, 1, -1000000, -32768, -32768));
    send_tick(make_tick(1, 1, 32767, 0, 1, 2, 20000, 1, -1));
    send_tick(make_tick(50000, 1, -32768, 100, 1, 3, 20000, 0, 0));    // other frame
    send_tick(make_tick(0, 0, 0, 0, 0, 0, 0, 0, 0));                   // ignored
    send_tick(make_tick(20000, 0, 5000, 4000, 1, 0, 90000, 500, -500)); // no setpoint
    send_tick(make_tick(30000, 1, 12868, 2000, 0, 0, 90000, 0, 0));    // no elevation
    send_tick(make_tick(250000, 1, -12868, 2500, 1, 1, 30000, -200, 300));
    send_tick(make_tick(20'h80000, 1, 16'h8000, 16'h7FFF, 1, 2, 21'h0FFFFF, 16'h7FFF, 0));
    send_tick(make_tick(20'h55555, 1, 16'h5555, 16'h5555, 1, 1, 21'h155555, 16'h5555, 16'h5555));
    send_tick(make_tick(20'hAAAAA, 1, 16'hAAAA, 16'hAAAA, 1, 0, 21'h0AAAAA, 16'hAAAA, 16'hAAAA));
  endtask

  // Proportional servo with a lag and a real acceleration limit, then the widest limits, then all zero.
  task automatic test_servo_and_lag;
    drain();
    cfg_all(384, 200000, 4096, 3000, 1500, 2000, 1000, 50000);
    send_tick(make_tick(100000, 1, 25000, -3000, 1, 0, 40000, 0, 0));
    send_tick(make_tick(100000, 1, -25000, 3000, 1, 1, 10000, 0, 0));
    send_tick(make_tick(500000, 1, 100, 32767, 1, 2, -50, 0, 0));
    drain();
    cfg_all(65535, 24'hFFFFFF, 32767, 32767, 32767, 65535, 32767, 20'hFFFFF);
    send_tick(make_tick(20'hFFFFF, 1, -20000, -32768, 1, 0, 1000000, 32767, -32768));
    send_tick(make_tick(10, 1, 20000, 32767, 1, 1, 0, 0, 0));
    drain();
    cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
    send_tick(make_tick(100000, 1, 10000, 1000, 1, 0, 5000, 300, 300));
  endtask

  // Depth above a freshly lowered floor stays put until a depth update pulls it down.
  task automatic test_lowered_floor;
    drain();
    cfg_all(0, 0, 2048, 5000, 0, 1000, 32767, 200000);
    send_tick(make_tick(1000000, 1, 0, 0, 1, 0, 150000, 0, 0));
    send_tick(make_tick(1000000, 1, 0, 0, 1, 0, 150000, 0, 0));
    drain();
    cfg_write(rlvk_pkg::REG_FLOOR_DEPTH, 60000);
    send_tick(make_tick(10000, 1, 0, 0, 1, 3, 0, 0, 0));
    send_tick(make_tick(10000, 1, 0, 0, 0, 0, 0, 0, 0));
    send_tick(make_tick(10000, 1, 0, 0, 1, 0, 10000, 0, 0));
  endtask

  // Random ticks under a series of register settings, including both extremes.
  task automatic test_random_phases;
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      case (ph)
        0: cfg_all(0, 0, 2048, 5000, 0, 0, 500, 100000);
        1: cfg_all(0, 0, 32767, 32767, 32767, 65535, 32767, 20'hFFFFF);
        2: cfg_all(65535, 24'hFFFFFF, 0, 0, 0, 0, 0, 0);
        default:
          cfg_all($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535),
                  $urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 2000000),
                  $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(0, 65535),
                  $urandom_range(0, 32767), $urandom_range(0, 1000000));
      endcase
      // One phase runs flat out on both sides, the others with random gaps.
      no_idle = (ph == 4);
      for (int n = 0; n < 100; n++) begin
        send_tick(random_tick());
        // Halfway through each phase, hold the next tick back until every pose has come out.
        if (n == 50) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (expected_poses.size() != 0);
        end
      end
      no_idle = 0;
    end
  endtask

  initial begin
    mismatches        = 0;
    no_idle           = 0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    tick_us_i         = '0;
    setpoint_valid_i  = 1'b0;
    target_heading_i  = '0;
    target_speed_i    = '0;
    elevation_valid_i = 1'b0;
    elevation_frame_i = '0;
    elevation_i       = '0;
    current_east_i    = '0;
    current_north_i   = '0;
    // Reset values of the registers and a vehicle at rest at the origin.
    gain_q8 = 0; lag_us = 0; turn_lim = 2048; fwd_lim = 5000; rev_lim = 0;
    accel_lim = 0; depth_rate_lim = 500; floor_mm = 100000;
    veh_heading = 0; veh_yaw = 0; veh_speed = 0; veh_depth = 0;
    veh_east = '0; veh_north = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_servo_and_lag();
    test_lowered_floor();
    test_random_phases();
    drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
